@@ hw/rtl/rmpc_pkg.sv @@
// Shared constants, control struct and root table for the range map power curve.
// No dependencies; every module of the block imports this package.
package rmpc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_BOUND_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_BOUND_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_BOUND_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_BOUND_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_EXP    = 3'd4;

  localparam logic [63:0] RST_IN_BOUND_A  = 64'hFFFF_FFFF_FFFF_0000;
  localparam logic [63:0] RST_IN_BOUND_B  = 64'h0000_0000_0001_0000;
  localparam logic [63:0] RST_OUT_BOUND_A = 64'h0000_0000_0000_0000;
  localparam logic [63:0] RST_OUT_BOUND_B = 64'h0000_0000_0001_0000;

  localparam int EXP_W = 16;
  localparam int EXP_FRAC = 12;
  localparam logic [EXP_W-1:0] EXP_ONE = 16'd4096;

  localparam int QUO_FRAC = 16;
  localparam int QUO_W = 23;
  localparam int LIMIT_BITS = QUO_W - QUO_FRAC;
  localparam logic [QUO_W-1:0] X_LIMIT_Q = 23'h7F_0000;

  localparam int LOG_FRAC = 24;
  localparam int ZW = 31;
  localparam int ZFRAC = 30;
  localparam int SHIFT_W = 12;

  localparam int Y_WIDTH_DEF = 50;

  typedef struct packed {
    logic valid;
    logic neg;
    logic dz;
  } rmpc_ctl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // root of two to the power two to the minus idx, Q30
  function automatic logic [ZW-1:0] root_q30(input int idx);
    logic [63:0] r;
    r = isqrt64(64'd1 << 61);
    for (int k = 2; k <= idx; k++) begin
      r = isqrt64(r << ZFRAC);
    end
    return r[ZW-1:0];
  endfunction

endpackage

@@ hw/rtl/rmpc_div.sv @@
// Normalizer: offset against the low input bound and restoring division, one bit a stage.
// Depends on rmpc_pkg.
module rmpc_div #(
  parameter int SW = rmpc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [SW-1:0]    sample,
  input  logic signed [SW-1:0]    lo_in,
  input  logic [SW-1:0]           den,
  output rmpc_pkg::rmpc_ctl_t     out_ctl,
  output logic [rmpc_pkg::QUO_W-1:0] mx
);
  import rmpc_pkg::*;

  localparam int STEPS = QUO_W;

  logic [SW:0]   num;
  logic [SW-1:0] mag;
  rmpc_ctl_t     ctl0;
  logic [SW-1:0] a0;
  logic [SW+LIMIT_BITS-1:0] den_lim;
  logic          clamp0;

  rmpc_ctl_t           ctl_r   [1:STEPS];
  logic [SW-1:0]       p_r     [1:STEPS];
  logic [STEPS-1:0]    q_r     [1:STEPS];
  logic [LIMIT_BITS-1:0] low_r [1:STEPS];
  logic                clamp_r [1:STEPS];

  assign num = {sample[SW-1], sample} - {lo_in[SW-1], lo_in};
  assign mag = num[SW] ? SW'(-num) : num[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0.valid <= 1'b0;
    end else begin
      ctl0.valid <= in_valid;
    end
    ctl0.neg <= num[SW];
    ctl0.dz  <= (den == '0);
    a0       <= mag;
  end

  assign den_lim = {den, {LIMIT_BITS{1'b0}}} - {{LIMIT_BITS{1'b0}}, den};
  assign clamp0  = ({{LIMIT_BITS{1'b0}}, a0} >= den_lim);

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [SW-1:0]         p_src;
    logic [STEPS-1:0]      q_src;
    logic [LIMIT_BITS-1:0] l_src;
    logic                  c_src;
    rmpc_ctl_t             k_src;
    logic                  bit_in;
    logic [SW:0]           trial;
    logic                  take;

    if (j == 0) begin : g_first
      assign p_src = a0 >> LIMIT_BITS;
      assign q_src = '0;
      assign l_src = a0[LIMIT_BITS-1:0];
      assign c_src = clamp0;
      assign k_src = ctl0;
    end else begin : g_next
      assign p_src = p_r[j];
      assign q_src = q_r[j];
      assign l_src = low_r[j];
      assign c_src = clamp_r[j];
      assign k_src = ctl_r[j];
    end

    if (j < LIMIT_BITS) begin : g_bit
      assign bit_in = l_src[LIMIT_BITS-1-j];
    end else begin : g_zero
      assign bit_in = 1'b0;
    end

    assign trial = {p_src, bit_in};
    assign take  = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_r[j+1].valid <= 1'b0;
      end else begin
        ctl_r[j+1].valid <= k_src.valid;
      end
      ctl_r[j+1].neg <= k_src.neg;
      ctl_r[j+1].dz  <= k_src.dz;
      p_r[j+1]       <= take ? SW'(trial - {1'b0, den}) : trial[SW-1:0];
      q_r[j+1]       <= {q_src[STEPS-2:0], take};
      low_r[j+1]     <= l_src;
      clamp_r[j+1]   <= c_src;
    end
  end

  assign out_ctl = ctl_r[STEPS];
  assign mx      = clamp_r[STEPS] ? X_LIMIT_Q : q_r[STEPS];

  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    ctl_r[STEPS].valid && !clamp_r[STEPS] |-> q_r[STEPS] < X_LIMIT_Q)
    else $error("unclamped quotient reached the magnitude limit");

endmodule

@@ hw/rtl/rmpc_pow.sv @@
// Power curve: log2 by repeated squaring, exponent multiply, and 2^T by a chain of roots.
// Depends on rmpc_pkg.
module rmpc_pow #(
  parameter int Y_WIDTH = rmpc_pkg::Y_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rmpc_pkg::rmpc_ctl_t          in_ctl,
  input  logic [rmpc_pkg::QUO_W-1:0]   mx,
  input  logic [rmpc_pkg::EXP_W-1:0]   expo,
  output rmpc_pkg::rmpc_ctl_t          out_ctl,
  output logic [Y_WIDTH-1:0]           y,
  output logic                         big
);
  import rmpc_pkg::*;

  localparam int LG_W = 6 + LOG_FRAC;
  localparam int PM_W = LG_W + EXP_W + 1;
  localparam int N_LO = EXP_FRAC + LOG_FRAC;
  localparam int N_W  = PM_W - N_LO;

  function automatic logic [4:0] msb_pos(input logic [QUO_W-1:0] v);
    logic [4:0] pos;
    pos = '0;
    for (int k = 0; k < QUO_W; k++) begin
      if (v[k]) pos = 5'(k);
    end
    return pos;
  endfunction

  logic [EXP_W-1:0] e_eff;

  rmpc_ctl_t        ctl_a;
  logic [QUO_W-1:0] mx_a;
  logic [EXP_W-1:0] e_a;
  logic             byp_a;
  logic [4:0]       p_a;

  rmpc_ctl_t        sq_ctl  [0:LOG_FRAC];
  logic [QUO_W-1:0] sq_mx   [0:LOG_FRAC];
  logic [EXP_W-1:0] sq_e    [0:LOG_FRAC];
  logic             sq_byp  [0:LOG_FRAC];
  logic [4:0]       sq_p    [0:LOG_FRAC];
  logic [ZW-1:0]    sq_z    [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] sq_f [0:LOG_FRAC];

  logic [5:0]             p_off;
  logic signed [LG_W-1:0] lg;
  logic signed [EXP_W:0]  e_s;
  rmpc_ctl_t              ctl_m;
  logic [QUO_W-1:0]       mx_m;
  logic                   byp_m;
  logic signed [PM_W-1:0] prod_m;

  rmpc_ctl_t           rt_ctl [1:LOG_FRAC];
  logic [QUO_W-1:0]    rt_mx  [1:LOG_FRAC];
  logic                rt_byp [1:LOG_FRAC];
  logic [ZW-1:0]       rt_acc [1:LOG_FRAC];
  logic [LOG_FRAC-1:0] rt_f   [1:LOG_FRAC];
  logic signed [SHIFT_W-1:0] rt_s [1:LOG_FRAC];

  logic signed [SHIFT_W-1:0] sv;
  logic [SHIFT_W-1:0]        nsh;
  logic                      huge;
  logic [62:0]               ywide;
  logic                      big_next;

  assign e_eff = (expo == '0) ? EXP_ONE : expo;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid <= 1'b0;
    end else begin
      ctl_a.valid <= in_ctl.valid;
    end
    ctl_a.neg <= in_ctl.neg;
    ctl_a.dz  <= in_ctl.dz;
    mx_a      <= mx;
    e_a       <= e_eff;
    byp_a     <= (e_eff == EXP_ONE) || (mx == '0);
  end

  assign p_a = msb_pos(mx_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_ctl[0].valid <= 1'b0;
    end else begin
      sq_ctl[0].valid <= ctl_a.valid;
    end
    sq_ctl[0].neg <= ctl_a.neg;
    sq_ctl[0].dz  <= ctl_a.dz;
    sq_mx[0]      <= mx_a;
    sq_e[0]       <= e_a;
    sq_byp[0]     <= byp_a;
    sq_p[0]       <= p_a;
    sq_z[0]       <= ZW'(mx_a) << (5'(ZFRAC) - p_a);
    sq_f[0]       <= '0;
  end

  for (genvar j = 0; j < LOG_FRAC; j++) begin : g_sq
    logic [2*ZW-1:0] zz;
    logic            set;
    assign zz  = (2*ZW)'(sq_z[j]) * (2*ZW)'(sq_z[j]);
    assign set = zz[2*ZW-1];
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_ctl[j+1].valid <= 1'b0;
      end else begin
        sq_ctl[j+1].valid <= sq_ctl[j].valid;
      end
      sq_ctl[j+1].neg <= sq_ctl[j].neg;
      sq_ctl[j+1].dz  <= sq_ctl[j].dz;
      sq_mx[j+1]      <= sq_mx[j];
      sq_e[j+1]       <= sq_e[j];
      sq_byp[j+1]     <= sq_byp[j];
      sq_p[j+1]       <= sq_p[j];
      sq_z[j+1]       <= set ? zz[2*ZW-1:ZFRAC+1] : zz[2*ZW-2:ZFRAC];
      sq_f[j+1]       <= {sq_f[j][LOG_FRAC-2:0], set};
    end
  end

  assign p_off = {1'b0, sq_p[LOG_FRAC]} - 6'd16;
  assign lg    = {p_off, sq_f[LOG_FRAC]};
  assign e_s   = {1'b0, sq_e[LOG_FRAC]};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_m.valid <= 1'b0;
    end else begin
      ctl_m.valid <= sq_ctl[LOG_FRAC].valid;
    end
    ctl_m.neg <= sq_ctl[LOG_FRAC].neg;
    ctl_m.dz  <= sq_ctl[LOG_FRAC].dz;
    mx_m      <= sq_mx[LOG_FRAC];
    byp_m     <= sq_byp[LOG_FRAC];
    prod_m    <= lg * e_s;
  end

  for (genvar r = 0; r < LOG_FRAC; r++) begin : g_root
    localparam logic [ZW-1:0] ROOT = root_q30(r + 1);
    rmpc_ctl_t           k_src;
    logic [QUO_W-1:0]    m_src;
    logic                b_src;
    logic [ZW-1:0]       a_src;
    logic [LOG_FRAC-1:0] f_src;
    logic [SHIFT_W-1:0]  s_src;
    logic [2*ZW-1:0]     pr;

    if (r == 0) begin : g_first
      logic [N_W-1:0] n_sl;
      assign n_sl  = prod_m[PM_W-1:N_LO];
      assign k_src = ctl_m;
      assign m_src = mx_m;
      assign b_src = byp_m;
      assign a_src = ZW'(1) << ZFRAC;
      assign f_src = prod_m[N_LO-1:EXP_FRAC];
      assign s_src = SHIFT_W'({{(SHIFT_W-N_W){n_sl[N_W-1]}}, n_sl} - SHIFT_W'(14));
    end else begin : g_next
      assign k_src = rt_ctl[r];
      assign m_src = rt_mx[r];
      assign b_src = rt_byp[r];
      assign a_src = rt_acc[r];
      assign f_src = rt_f[r];
      assign s_src = rt_s[r];
    end

    assign pr = (2*ZW)'(a_src) * (2*ZW)'(ROOT);

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_ctl[r+1].valid <= 1'b0;
      end else begin
        rt_ctl[r+1].valid <= k_src.valid;
      end
      rt_ctl[r+1].neg <= k_src.neg;
      rt_ctl[r+1].dz  <= k_src.dz;
      rt_mx[r+1]      <= m_src;
      rt_byp[r+1]     <= b_src;
      rt_f[r+1]       <= f_src;
      rt_s[r+1]       <= s_src;
      rt_acc[r+1]     <= f_src[LOG_FRAC-1-r] ? pr[ZFRAC+ZW-1:ZFRAC] : a_src;
    end
  end

  assign sv   = rt_s[LOG_FRAC];
  assign nsh  = SHIFT_W'(-sv);
  assign huge = (sv >= 12'sd33);

  always_comb begin
    if (rt_byp[LOG_FRAC]) begin
      ywide = 63'(rt_mx[LOG_FRAC]);
    end else if (huge) begin
      ywide = '0;
    end else if (!sv[SHIFT_W-1]) begin
      ywide = 63'(rt_acc[LOG_FRAC]) << sv[5:0];
    end else if (nsh >= SHIFT_W'(64)) begin
      ywide = '0;
    end else begin
      ywide = 63'(rt_acc[LOG_FRAC]) >> nsh[5:0];
    end
  end

  assign big_next = !rt_byp[LOG_FRAC] && (huge || ((ywide >> Y_WIDTH) != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= rt_ctl[LOG_FRAC].valid;
    end
    out_ctl.neg <= rt_ctl[LOG_FRAC].neg;
    out_ctl.dz  <= rt_ctl[LOG_FRAC].dz;
    y           <= ywide[Y_WIDTH-1:0];
    big         <= big_next;
  end

  a_byp_small: assert property (@(posedge clk) disable iff (rst)
    rt_ctl[LOG_FRAC].valid && rt_byp[LOG_FRAC] |=> !big)
    else $error("linear curve item flagged as overflowing");

endmodule

@@ hw/rtl/rmpc_scale.sv @@
// Output scaling: split multiply by the output range, offset by the low bound, saturate.
// Depends on rmpc_pkg.
module rmpc_scale #(
  parameter int SW      = rmpc_pkg::SAMPLE_WIDTH_DEF,
  parameter int Y_WIDTH = rmpc_pkg::Y_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rmpc_pkg::rmpc_ctl_t  in_ctl,
  input  logic [Y_WIDTH-1:0]   y,
  input  logic                 big,
  input  logic [SW-1:0]        rng,
  input  logic signed [SW-1:0] lo_out,
  output logic                 done,
  output logic signed [SW-1:0] sample_out,
  output logic                 saturated
);
  import rmpc_pkg::*;

  localparam int YLW = Y_WIDTH / 2;
  localparam int YHW = Y_WIDTH - YLW;
  localparam int RLW = SW / 2;
  localparam int RHW = SW - RLW;
  localparam int PW  = Y_WIDTH + SW;
  localparam int QW  = PW - QUO_FRAC;
  localparam logic [QW-1:0] CAP = QW'(1) << (SW + 1);

  rmpc_ctl_t            ctl1;
  logic                 big1;
  logic [YLW+RLW-1:0]   pll;
  logic [YLW+RHW-1:0]   plh;
  logic [YHW+RLW-1:0]   phl;
  logic [YHW+RHW-1:0]   phh;

  rmpc_ctl_t            ctl2;
  logic                 big2;
  logic [PW-1:0]        pa;
  logic [PW-1:0]        pb;

  logic [PW-1:0]        prod;
  rmpc_ctl_t            ctl3;
  logic                 qsat3;
  logic [SW+1:0]        q3;

  logic [SW+2:0]        res;
  logic                 in_range;
  logic signed [SW-1:0] sat_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else begin
      ctl1.valid <= in_ctl.valid;
    end
    ctl1.neg <= in_ctl.neg;
    ctl1.dz  <= in_ctl.dz;
    big1     <= big && (rng != '0);
    pll      <= y[YLW-1:0] * rng[RLW-1:0];
    plh      <= y[YLW-1:0] * rng[SW-1:RLW];
    phl      <= y[Y_WIDTH-1:YLW] * rng[RLW-1:0];
    phh      <= y[Y_WIDTH-1:YLW] * rng[SW-1:RLW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid <= 1'b0;
    end else begin
      ctl2.valid <= ctl1.valid;
    end
    ctl2.neg <= ctl1.neg;
    ctl2.dz  <= ctl1.dz;
    big2     <= big1;
    pa       <= {phh, pll};
    pb       <= (PW'(plh) << RLW) + (PW'(phl) << YLW);
  end

  assign prod = pa + pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else begin
      ctl3.valid <= ctl2.valid;
    end
    ctl3.neg <= ctl2.neg;
    ctl3.dz  <= ctl2.dz;
    qsat3    <= big2 || (prod[PW-1:QUO_FRAC] > CAP);
    q3       <= prod[QUO_FRAC+SW+1:QUO_FRAC];
  end

  assign res = ctl3.neg ? ({{3{lo_out[SW-1]}}, lo_out} - {1'b0, q3})
                        : ({{3{lo_out[SW-1]}}, lo_out} + {1'b0, q3});
  assign in_range = (res[SW+2:SW-1] == '0) || (res[SW+2:SW-1] == '1);
  assign sat_val  = ctl3.neg ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl3.valid;
    end
    if (ctl3.dz) begin
      sample_out <= lo_out;
      saturated  <= 1'b1;
    end else if (qsat3) begin
      sample_out <= sat_val;
      saturated  <= 1'b1;
    end else if (!in_range) begin
      sample_out <= res[SW+2] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      saturated  <= 1'b1;
    end else begin
      sample_out <= res[SW-1:0];
      saturated  <= 1'b0;
    end
  end

  a_qsat_flag: assert property (@(posedge clk) disable iff (rst)
    ctl3.valid && qsat3 && !ctl3.dz |=> done && saturated)
    else $error("overflowing product delivered without the saturation flag");

endmodule

@@ hw/rtl/range_map_power_curve.sv @@
// Range map with power curve: one signed sample in, one mapped sample and clip flag out.
// The result strobes on done after the divider, power and scaling pipelines; throughput one
// request per cycle, set by the fully pipelined divider, log, root and multiply chains.
// busy never rises and the result cannot be stalled; it shows on done for one cycle.
// Reset clears every pipeline valid bit and loads the bound and exponent defaults.
// Depends on rmpc_pkg, rmpc_div, rmpc_pow and rmpc_scale.
module range_map_power_curve #(
  parameter int SAMPLE_WIDTH = rmpc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_in,
  output logic                            done,
  output logic signed [SAMPLE_WIDTH-1:0]  sample_out,
  output logic                            saturated,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rmpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [SAMPLE_WIDTH-1:0]         cfg_data
);
  import rmpc_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int YW  = (SW + 18 < 63) ? SW + 18 : 63;
  localparam int LAT = QUO_W + 2 * LOG_FRAC + 9;

  logic signed [SW-1:0] in_bound_a;
  logic signed [SW-1:0] in_bound_b;
  logic signed [SW-1:0] out_bound_a;
  logic signed [SW-1:0] out_bound_b;
  logic [EXP_W-1:0]     curve_exponent;

  logic signed [SW-1:0] lo_in;
  logic signed [SW-1:0] hi_in;
  logic signed [SW-1:0] lo_out;
  logic signed [SW-1:0] hi_out;
  logic [SW:0]          den_wide;
  logic [SW:0]          rng_wide;

  rmpc_ctl_t          div_ctl;
  logic [QUO_W-1:0]   div_mx;
  rmpc_ctl_t          pow_ctl;
  logic [YW-1:0]      pow_y;
  logic               pow_big;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_bound_a     <= RST_IN_BOUND_A[SW-1:0];
      in_bound_b     <= RST_IN_BOUND_B[SW-1:0];
      out_bound_a    <= RST_OUT_BOUND_A[SW-1:0];
      out_bound_b    <= RST_OUT_BOUND_B[SW-1:0];
      curve_exponent <= EXP_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IN_BOUND_A:  in_bound_a     <= cfg_data;
        CFG_IN_BOUND_B:  in_bound_b     <= cfg_data;
        CFG_OUT_BOUND_A: out_bound_a    <= cfg_data;
        CFG_OUT_BOUND_B: out_bound_b    <= cfg_data;
        CFG_CURVE_EXP:   curve_exponent <= cfg_data[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  assign lo_in    = (in_bound_a < in_bound_b) ? in_bound_a : in_bound_b;
  assign hi_in    = (in_bound_a < in_bound_b) ? in_bound_b : in_bound_a;
  assign lo_out   = (out_bound_a < out_bound_b) ? out_bound_a : out_bound_b;
  assign hi_out   = (out_bound_a < out_bound_b) ? out_bound_b : out_bound_a;
  assign den_wide = {hi_in[SW-1], hi_in} - {lo_in[SW-1], lo_in};
  assign rng_wide = {hi_out[SW-1], hi_out} - {lo_out[SW-1], lo_out};

  rmpc_div #(
    .SW (SW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .sample   (sample_in),
    .lo_in    (lo_in),
    .den      (den_wide[SW-1:0]),
    .out_ctl  (div_ctl),
    .mx       (div_mx)
  );

  rmpc_pow #(
    .Y_WIDTH (YW)
  ) u_pow (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (div_ctl),
    .mx      (div_mx),
    .expo    (curve_exponent),
    .out_ctl (pow_ctl),
    .y       (pow_y),
    .big     (pow_big)
  );

  rmpc_scale #(
    .SW      (SW),
    .Y_WIDTH (YW)
  ) u_scale (
    .clk        (clk),
    .rst        (rst),
    .in_ctl     (pow_ctl),
    .y          (pow_y),
    .big        (pow_big),
    .rng        (rng_wide[SW-1:0]),
    .lo_out     (lo_out),
    .done       (done),
    .sample_out (sample_out),
    .saturated  (saturated)
  );

  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching request");

endmodule
